@@ hw/rtl/utwe_pkg.sv @@
// Shared types, codes and helpers for the UTF-8 text width engine.
// Used by utwe_decode, utwe_rsp_fifo and utf8_text_width_engine; no dependencies.
package utwe_pkg;

   // byte classes and sequence bounds
   localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
   localparam logic [7:0] BYTE_LEAD2_MAX = 8'hDF;
   localparam logic [7:0] BYTE_LEAD2_MIN = 8'hC2;
   localparam logic [7:0] BYTE_LEAD3_MIN = 8'hE0;
   localparam logic [7:0] BYTE_LEAD3_MAX = 8'hEF;
   localparam logic [7:0] BYTE_CONT_MIN  = 8'h80;
   localparam logic [7:0] BYTE_CONT_MAX  = 8'hBF;
   localparam logic [7:0] BYTE_SPACE     = 8'h20;
   localparam logic [7:0] BYTE_TAB       = 8'h09;
   localparam logic [15:0] CODE_SPACE    = 16'h0020;

   // sequence length codes
   localparam logic [1:0] SEQ_LEN_ONE   = 2'd1;
   localparam logic [1:0] SEQ_LEN_TWO   = 2'd2;
   localparam logic [1:0] SEQ_LEN_THREE = 2'd3;

   // what a decoded byte does to the position
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_SPACE = 2'd1;
   localparam logic [1:0] KIND_TAB   = 2'd2;
   localparam logic [1:0] KIND_GLYPH = 2'd3;

   // request operations
   localparam logic OP_WRITE_ENTRY = 1'b0;
   localparam logic OP_TEXT_BYTE   = 1'b1;

   localparam logic [7:0] SPACE_ADVANCE = 8'd4;
   localparam logic [4:0] TAB_REACH     = 5'd16;
   localparam logic [3:0] TAB_PITCH     = 4'd12;
   localparam logic [3:0] TAB_LEAD      = 4'd4;

   localparam int RSP_DEPTH    = 8;
   localparam int RSP_PTR_BITS = 3;
   localparam int RSP_PUSHES   = 3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] code;
   } dec_type;

   typedef struct packed {
      logic [15:0] position;
      logic        final_res;
   } rsp_item_type;

   typedef struct packed {
      logic [RSP_PUSHES-1:0]               valid;
      rsp_item_type [RSP_PUSHES-1:0]       item;
   } rsp_push_type;

   // remainder by twelve of a value below 512, restoring style
   function automatic logic [3:0] mod12(input logic [8:0] v);
      logic [8:0] t;
      t = v;
      for (int k = 5; k >= 0; k--) begin
         if (t >= (9'd12 << k)) begin
            t = t - (9'd12 << k);
         end
      end
      return t[3:0];
   endfunction

endpackage

@@ hw/rtl/utwe_decode.sv @@
// UTF-8 byte grouping and sequence check; holds the decoder state registers.
// Depends on utwe_pkg.
module utwe_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               start,
   input  logic [7:0]         text_byte,
   output utwe_pkg::dec_type  dec
);

   logic [1:0]  len_ff, len_in, len_cur;
   logic        cont_ff, cont_in, cont_cur;
   logic [23:0] tag_ff, tag_in, tag_cur;
   logic        ascii, multi;
   logic [1:0]  done_len;
   logic [7:0]  c0, c1, c2;
   logic        ok0, ok1, seq_ok;
   logic [15:0] mb_code;

   always_comb begin
      len_cur  = start ? utwe_pkg::SEQ_LEN_ONE : len_ff;
      cont_cur = start ? 1'b0 : cont_ff;
      tag_cur  = start ? 24'd0 : tag_ff;
      len_in   = len_cur;
      cont_in  = cont_cur;
      tag_in   = tag_cur;
      ascii    = 1'b0;
      multi    = 1'b0;
      done_len = len_cur;
      if (len_cur == utwe_pkg::SEQ_LEN_ONE) begin
         if (text_byte > utwe_pkg::BYTE_ASCII_MAX) begin
            if (text_byte <= utwe_pkg::BYTE_LEAD2_MAX) begin
               len_in  = utwe_pkg::SEQ_LEN_TWO;
               cont_in = 1'b0;
               tag_in  = {8'd0, text_byte, 8'd0};
            end else begin
               len_in  = utwe_pkg::SEQ_LEN_THREE;
               cont_in = 1'b1;
               tag_in  = {text_byte, 16'd0};
            end
         end else begin
            ascii = 1'b1;
         end
      end else if (cont_cur) begin
         tag_in  = tag_cur | {8'd0, text_byte, 8'd0};
         cont_in = 1'b0;
      end else begin
         tag_in = tag_cur | {16'd0, text_byte};
         len_in = utwe_pkg::SEQ_LEN_ONE;
         multi  = 1'b1;
      end

      c0  = tag_in[7:0];
      c1  = tag_in[15:8];
      c2  = tag_in[23:16];
      ok0 = (c0 >= utwe_pkg::BYTE_CONT_MIN) && (c0 <= utwe_pkg::BYTE_CONT_MAX);
      ok1 = (c1 >= utwe_pkg::BYTE_CONT_MIN) && (c1 <= utwe_pkg::BYTE_CONT_MAX);
      if (done_len == utwe_pkg::SEQ_LEN_TWO) begin
         seq_ok  = (c1 >= utwe_pkg::BYTE_LEAD2_MIN) && (c1 <= utwe_pkg::BYTE_LEAD2_MAX) && ok0;
         mb_code = {5'd0, c1[4:0], c0[5:0]};
      end else begin
         seq_ok  = (c2 >= utwe_pkg::BYTE_LEAD3_MIN) && (c2 <= utwe_pkg::BYTE_LEAD3_MAX)
                   && ok1 && ok0;
         mb_code = {c2[3:0], c1[5:0], c0[5:0]};
      end

      dec.kind = utwe_pkg::KIND_NONE;
      dec.code = {8'd0, text_byte};
      if (ascii) begin
         if (text_byte == utwe_pkg::BYTE_SPACE) begin
            dec.kind = utwe_pkg::KIND_SPACE;
         end else if (text_byte == utwe_pkg::BYTE_TAB) begin
            dec.kind = utwe_pkg::KIND_TAB;
         end else if (text_byte > utwe_pkg::BYTE_SPACE) begin
            dec.kind = utwe_pkg::KIND_GLYPH;
         end
      end else if (multi && seq_ok) begin
         dec.code = mb_code;
         if (mb_code > utwe_pkg::CODE_SPACE) begin
            dec.kind = utwe_pkg::KIND_GLYPH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= utwe_pkg::SEQ_LEN_ONE;
         cont_ff <= 1'b0;
         tag_ff  <= 24'd0;
      end else if (enable) begin
         len_ff  <= len_in;
         cont_ff <= cont_in;
         tag_ff  <= tag_in;
      end
   end

endmodule

@@ hw/rtl/utwe_rsp_fifo.sv @@
// Result queue: takes up to three items a cycle in order, gives one a cycle while rsp_tready is high.
// Depends on utwe_pkg.
module utwe_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  utwe_pkg::rsp_push_type  push,
   output logic [utwe_pkg::RSP_PTR_BITS:0] level,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,   // [15:0] position
   output logic                    rsp_tlast    // final_res
);

   localparam int PB = utwe_pkg::RSP_PTR_BITS;

   utwe_pkg::rsp_item_type slot_ff [utwe_pkg::RSP_DEPTH];
   logic [PB-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [PB:0]   count_ff, count_in;
   logic [PB-1:0] offset [utwe_pkg::RSP_PUSHES];
   logic [PB:0]   npush;
   logic          pop;

   always_comb begin
      npush = '0;
      for (int i = 0; i < utwe_pkg::RSP_PUSHES; i++) begin
         offset[i] = npush[PB-1:0];
         npush     = npush + (PB+1)'(push.valid[i]);
      end
      pop      = rsp_tvalid && rsp_tready;
      head_in  = head_ff + PB'(pop);
      tail_in  = tail_ff + npush[PB-1:0];
      count_in = count_ff + npush - (PB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < utwe_pkg::RSP_PUSHES; i++) begin
         if (push.valid[i]) begin
            slot_ff[tail_ff + offset[i]] <= push.item[i];
         end
      end
   end

   assign level      = count_ff;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = slot_ff[head_ff].position;
   assign rsp_tlast  = slot_ff[head_ff].final_res;

endmodule

@@ hw/rtl/utf8_text_width_engine.sv @@
// Top level of the UTF-8 text width engine: glyph metric memory, position update
// and configuration registers. Depends on utwe_pkg, utwe_decode and utwe_rsp_fifo.
//
//  channel  ports   direction  carries
//  -------  ------  ---------  ----------------------------------------------
//  request  req_*   in         glyph entry writes and text bytes
//  result   rsp_*   out        positions and the final total (tlast)
//  config   csr_*   in/out     mode at 0x0, font_select at 0x4
//
// One request per cycle while the result queue has room; the glyph memory read
// is registered and the position register is updated the cycle after, as the
// byte's results enter the result queue. Sustained rate is set by the result
// port: one result per cycle drains, and requests stall while the result queue
// holds more than two items. Reset clears the decoder, position, queue and
// registers; the glyph memory is not cleared and needs no clearing pass.
module utf8_text_width_engine #(
   parameter int CODE_BITS     = 16,
   parameter int POSITION_BITS = 16,
   parameter int FONT_COUNT    = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] text_byte, [23:8] entry_code, [24] entry_font, [32:25] entry_width,
   // [40:33] entry_height, [48:41] entry_advance, [55:49] zero
   input  logic [55:0] req_tdata,
   input  logic [1:0]  req_tuser,   // [0] operation, [1] string_start
   input  logic        req_tlast,   // string_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] position
   output logic        rsp_tlast,   // final_res
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DEPTH     = FONT_COUNT << CODE_BITS;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int PW        = POSITION_BITS;
   localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
   localparam logic [3:0] MAX_REM = 4'(((64'd1 << POSITION_BITS) - 64'd1) % 64'd12);
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_FONT = 1'b1;
   localparam int PB = utwe_pkg::RSP_PTR_BITS;
   localparam logic [PB:0] LEVEL_LIMIT = (PB+1)'(utwe_pkg::RSP_DEPTH - 2 * utwe_pkg::RSP_PUSHES);

   // configuration
   logic mode_ff, font_ff;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {31'd0, (csr_paddr[2] == REG_FONT) ? font_ff : mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         font_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_MODE) begin
            mode_ff <= csr_pwdata[0];
         end else begin
            font_ff <= csr_pwdata[0];
         end
      end
   end

   // request fields
   logic        op, str_start, str_end, accept, text_acc, write_acc;
   logic [7:0]  text_byte, e_width, e_height, e_adv;
   logic [15:0] e_code;
   logic        e_font;
   logic [PB:0] level;

   assign op        = req_tuser[0];
   assign str_start = req_tuser[1];
   assign str_end   = req_tlast;
   assign text_byte = req_tdata[7:0];
   assign e_code    = req_tdata[23:8];
   assign e_font    = req_tdata[24];
   assign e_width   = req_tdata[32:25];
   assign e_height  = req_tdata[40:33];
   assign e_adv     = req_tdata[48:41];

   assign req_tready = (level <= LEVEL_LIMIT);
   assign accept     = req_tvalid && req_tready;
   assign text_acc   = accept && (op == utwe_pkg::OP_TEXT_BYTE);
   assign write_acc  = accept && (op == utwe_pkg::OP_WRITE_ENTRY);

   // decode stage
   utwe_pkg::dec_type dec;

   utwe_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .enable    (text_acc),
      .start     (str_start),
      .text_byte (text_byte),
      .dec       (dec)
   );

   logic                 wr_ok, rd_ok;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [1:0]           kind_in;

   always_comb begin
      wr_ok   = (32'(e_font) < FONT_COUNT) && ((32'(e_code) >> CODE_BITS) == 32'd0);
      rd_ok   = (32'(font_ff) < FONT_COUNT) && ((32'(dec.code) >> CODE_BITS) == 32'd0);
      wr_addr = ADDR_BITS'((32'(e_font) << CODE_BITS) + 32'(e_code));
      rd_addr = ADDR_BITS'((32'(font_ff) << CODE_BITS) + 32'(dec.code));
      kind_in = dec.kind;
      if (dec.kind == utwe_pkg::KIND_GLYPH && !rd_ok) begin
         kind_in = utwe_pkg::KIND_NONE;
      end
   end

   // glyph metric memory: {advance, height, width}
   logic [23:0] glyph_mem [DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (write_acc && wr_ok) begin
         glyph_mem[wr_addr] <= {e_adv, e_height, e_width};
      end
      if (text_acc && kind_in == utwe_pkg::KIND_GLYPH) begin
         rd_data_ff <= glyph_mem[rd_addr];
      end
   end

   // update stage
   logic       b_valid_ff;
   logic [1:0] b_kind_ff;
   logic       b_start_ff, b_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= text_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (text_acc) begin
         b_kind_ff  <= kind_in;
         b_start_ff <= str_start;
         b_end_ff   <= str_end;
      end
   end

   logic [PW-1:0] pos_ff, pos_in, pos_cur;
   logic [3:0]    rem_ff, rem_in, rem_cur, rem_add, r4;
   logic [7:0]    add_amt, g_width, g_height;
   logic          add_en, tab_en, emit_step;
   logic [PW:0]   sum_add, sum_tab;
   logic [4:0]    tab_step, r_plus;
   logic [PW+15:0] pos_wide, zero_wide;
   utwe_pkg::rsp_push_type push;

   always_comb begin
      pos_cur  = b_start_ff ? '0 : pos_ff;
      rem_cur  = b_start_ff ? 4'd0 : rem_ff;
      g_width  = rd_data_ff[7:0];
      g_height = rd_data_ff[15:8];
      add_amt  = rd_data_ff[23:16];
      add_en   = 1'b0;
      tab_en   = 1'b0;
      emit_step = 1'b0;
      case (b_kind_ff)
         utwe_pkg::KIND_SPACE: begin
            add_amt   = utwe_pkg::SPACE_ADVANCE;
            add_en    = 1'b1;
            emit_step = !mode_ff;
         end
         utwe_pkg::KIND_TAB: begin
            tab_en    = 1'b1;
            emit_step = !mode_ff;
         end
         utwe_pkg::KIND_GLYPH: begin
            add_en    = mode_ff ? (g_height != 8'd0) : (g_width != 8'd0);
            emit_step = !mode_ff && (g_width != 8'd0);
         end
         default: begin
            add_en = 1'b0;
         end
      endcase

      sum_add = {1'b0, pos_cur} + (PW+1)'(add_amt);
      rem_add = utwe_pkg::mod12({1'b0, add_amt} + {5'd0, rem_cur});
      r_plus  = {1'b0, rem_cur} + {1'b0, utwe_pkg::TAB_LEAD};
      r4      = (r_plus >= {1'b0, utwe_pkg::TAB_PITCH}) ?
                4'(r_plus - {1'b0, utwe_pkg::TAB_PITCH}) : r_plus[3:0];
      tab_step = utwe_pkg::TAB_REACH - {1'b0, r4};
      sum_tab = {1'b0, pos_cur} + (PW+1)'(tab_step);

      pos_in = pos_cur;
      rem_in = rem_cur;
      if (add_en) begin
         if (sum_add[PW]) begin
            pos_in = POS_MAX;
            rem_in = MAX_REM;
         end else begin
            pos_in = sum_add[PW-1:0];
            rem_in = rem_add;
         end
      end else if (tab_en) begin
         if (sum_tab[PW]) begin
            pos_in = POS_MAX;
            rem_in = MAX_REM;
         end else begin
            pos_in = sum_tab[PW-1:0];
            rem_in = 4'd0;
         end
      end

      zero_wide = '0;
      pos_wide  = {16'd0, pos_in};

      push.valid[0]          = b_valid_ff && b_start_ff && !mode_ff;
      push.item[0].position  = zero_wide[15:0];
      push.item[0].final_res = 1'b0;
      push.valid[1]          = b_valid_ff && emit_step;
      push.item[1].position  = pos_wide[15:0];
      push.item[1].final_res = 1'b0;
      push.valid[2]          = b_valid_ff && b_end_ff;
      push.item[2].position  = pos_wide[15:0];
      push.item[2].final_res = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rem_ff <= 4'd0;
      end else if (b_valid_ff) begin
         pos_ff <= pos_in;
         rem_ff <= rem_in;
      end
   end

   utwe_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .level      (level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
